### rtl/assert_macros.svh
// assertion macros used by the ordered list module
// no dependencies; pulled in with `include where a module asserts
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, skipped while reset is applied
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every rising edge, reset included
`define ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/olasd_pkg.sv
// shared types and constants for the ordered list block
// no dependencies
`default_nettype none

package olasd_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = 4;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_EMPTY     = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] count;
  } rsp_t;

endpackage

`default_nettype wire

### rtl/ordered_list_append_search_delete.sv
// ordered list of signed values: append, search, delete with gap closing
// depends on olasd_pkg and assert_macros.svh
//
//   port group        | dir | handshake
//   ------------------+-----+--------------------------------------------
//   start, req_i      | in  | request taken when start high and busy low
//   busy              | out | high while a search or delete is in flight
//   valid_o, rsp_o    | out | one-cycle strobe, one result per request
//
// append, unused codes and delete on an empty list: result the cycle after
// the request, busy stays low. search and delete scan the entries from slot
// 0 up; delete then moves each entry behind the match down one slot. all of
// it runs through one read port and one write port of the entry memory and
// a single 32-bit equality compare. reset clears the count and the
// sequencer; entry contents are not cleared. results cannot be stalled.
`default_nettype none

module ordered_list_append_search_delete (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  input  wire olasd_pkg::req_t req_i,
  output logic                 busy,
  output logic                 valid_o,
  output olasd_pkg::rsp_t      rsp_o
);
  import olasd_pkg::*;

  `include "assert_macros.svh"

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   ptr_q, ptr_d;
  logic [IDX_W-1:0]   cmp_idx_q, cmp_idx_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [1:0]         cmd_q, cmd_d;
  logic signed [31:0] value_q, value_d;
  logic               valid_q, valid_d;
  rsp_t               rsp_q, rsp_d;

  logic signed [31:0] mem_q [DEPTH];
  logic signed [31:0] rd_q;
  logic               rd_en;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic signed [31:0] mem_wdata;
  logic               hit;

  assign rd_en = (state_q != S_IDLE) && (ptr_q < count_q);
  assign hit   = cmp_vld_q && (rd_q == value_q);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    cmp_idx_d = cmp_idx_q;
    cmp_vld_d = 1'b0;
    cmd_d     = cmd_q;
    value_d   = value_q;
    valid_d   = 1'b0;
    rsp_d     = rsp_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = rd_q;

    // one read issued per cycle while scanning or shifting, until the pointer reaches the count
    if (rd_en) begin
      cmp_vld_d = 1'b1;
      cmp_idx_d = ptr_q[IDX_W-1:0];
      ptr_d     = ptr_q + CNT_W'(1);
    end

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d   = req_i.command;
          value_d = req_i.value;
          ptr_d   = '0;
          rsp_d.position = '0;
          case (req_i.command)
            CMD_APPEND: begin
              valid_d = 1'b1;
              if (count_q == CNT_W'(DEPTH)) begin
                rsp_d.status = STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_q[IDX_W-1:0];
                mem_wdata = req_i.value;
                count_d   = count_q + CNT_W'(1);
                rsp_d.status = STAT_OK;
              end
              rsp_d.count = count_d;
            end
            CMD_SEARCH: begin
              state_d = S_SCAN;
            end
            CMD_DELETE: begin
              if (count_q == '0) begin
                valid_d      = 1'b1;
                rsp_d.status = STAT_EMPTY;
                rsp_d.count  = count_q;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: begin
              valid_d      = 1'b1;
              rsp_d.status = STAT_OK;
              rsp_d.count  = count_q;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (cmd_q == CMD_SEARCH) begin
            state_d        = S_IDLE;
            valid_d        = 1'b1;
            rsp_d.status   = STAT_OK;
            rsp_d.position = POS_W'(cmp_idx_q);
            rsp_d.count    = count_q;
          end else begin
            state_d = S_SHIFT;
          end
        end else if (!cmp_vld_q && !rd_en) begin
          state_d        = S_IDLE;
          valid_d        = 1'b1;
          rsp_d.status   = STAT_NOT_FOUND;
          rsp_d.position = '0;
          rsp_d.count    = count_q;
        end
      end
      S_SHIFT: begin
        // entry read last cycle moves down one slot
        if (cmp_vld_q) begin
          mem_we    = 1'b1;
          mem_waddr = cmp_idx_q - IDX_W'(1);
          mem_wdata = rd_q;
        end else begin
          count_d        = count_q - CNT_W'(1);
          state_d        = S_IDLE;
          valid_d        = 1'b1;
          rsp_d.status   = STAT_OK;
          rsp_d.position = '0;
          rsp_d.count    = count_d;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      ptr_q     <= '0;
      cmp_vld_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ptr_q     <= ptr_d;
      cmp_vld_q <= cmp_vld_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    cmd_q     <= cmd_d;
    value_q   <= value_d;
    rsp_q     <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem_q[ptr_q[IDX_W-1:0]];
    end
  end

  assign busy    = (state_q != S_IDLE);
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  `ASSERT_RST(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(DEPTH), "count above depth")
  `ASSERT_RST(a_rsp_count, clk_i, rst_ni, valid_o |-> (rsp_o.count == count_q),
    "reported count differs from stored count")
  `ASSERT_RST(a_rsp_idle, clk_i, rst_ni, valid_o |-> (state_q == S_IDLE),
    "result shown while sequencer busy")
  `ASSERT_RST(a_shift_addr, clk_i, rst_ni,
    (state_q == S_SHIFT && cmp_vld_q) |-> (cmp_idx_q != '0), "shift would write below slot 0")
  `ASSERT_RST(a_pos_ok, clk_i, rst_ni,
    (valid_o && rsp_o.position != '0) |-> (rsp_o.status == STAT_OK),
    "nonzero position on a failed request")

endmodule

`default_nettype wire
